// File: design/tfc_pkg.sv
// Shared types, format codes and integer helpers for the texel format converter.
// No dependencies; used by tfc_lane, texel_format_converter_core and the test files.
`timescale 1ns / 1ps
package tfc_pkg;

	localparam int unsigned MAX_COMPONENTS = 4;
	localparam int unsigned COMP_W         = 32;
	localparam int unsigned CNT_W          = 3;

	localparam logic [1:0] FMT_UNORM8  = 2'd0;
	localparam logic [1:0] FMT_UNORM16 = 2'd1;
	localparam logic [1:0] FMT_UNORM32 = 2'd2;
	localparam logic [1:0] FMT_FLOAT32 = 2'd3;

	localparam logic [1:0] REG_SOURCE_FORMAT     = 2'd0;
	localparam logic [1:0] REG_TARGET_FORMAT     = 2'd1;
	localparam logic [1:0] REG_SOURCE_COMPONENTS = 2'd2;
	localparam logic [1:0] REG_TARGET_COMPONENTS = 2'd3;

	typedef enum logic [1:0] {
		K_INT    = 2'd0,
		K_DIV    = 2'd1,
		K_U2F    = 2'd2,
		K_F2U    = 2'd3
	} tfc_kind_t;

	typedef struct packed {
		logic [1:0] sf;
		logic [1:0] tf;
	} tfc_mode_t;

	typedef struct packed {
		logic [COMP_W-1:0] in_comp0;
		logic [COMP_W-1:0] in_comp1;
		logic [COMP_W-1:0] in_comp2;
		logic [COMP_W-1:0] in_comp3;
	} tfc_in_t;

	typedef struct packed {
		logic [COMP_W-1:0] out_comp0;
		logic [COMP_W-1:0] out_comp1;
		logic [COMP_W-1:0] out_comp2;
		logic [COMP_W-1:0] out_comp3;
	} tfc_out_t;

	// floor(x / 257) for a 16-bit x
	function automatic logic [7:0] div257(input logic [15:0] x);
		logic [15:0] d;
		d = x - {8'd0, x[15:8]};
		return d[15:8];
	endfunction

	// floor(x / 65537) for a 32-bit x
	function automatic logic [15:0] div65537(input logic [31:0] x);
		logic [31:0] d;
		d = x - {16'd0, x[31:16]};
		return d[31:16];
	endfunction

	// leading zero count; caller guarantees x is non-zero where it matters
	function automatic logic [4:0] lzc32(input logic [31:0] x);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) begin
				n = 5'(31 - i);
			end
		end
		return n;
	endfunction

	// clamp a component count into 1..MAX_COMPONENTS
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
		if (c == '0) begin
			return CNT_W'(1);
		end
		if (c > CNT_W'(MAX_COMPONENTS)) begin
			return CNT_W'(MAX_COMPONENTS);
		end
		return c;
	endfunction

endpackage

// File: design/tfc_lane.sv
// One component lane of the converter: three register stages, advanced together.
// Depends on tfc_pkg.
`timescale 1ns / 1ps
module tfc_lane
	import tfc_pkg::*;
(
	input  logic        clk,
	input  logic        adv,
	input  tfc_mode_t   mode,
	input  logic        keep,
	input  logic [31:0] raw,
	output logic [31:0] res
);

	// stage 1 registers
	tfc_kind_t   kind_s1;
	logic [1:0]  tf_s1;
	logic        keep_s1;
	logic [31:0] ival_s1;
	logic        wide_s1;
	logic [4:0]  lz_s1;
	logic [39:0] prod_s1;
	logic [7:0]  e_s1;
	logic        nan_s1, neg_s1, inf_s1, ez_s1;

	// stage 2 registers
	tfc_kind_t   kind_s2;
	logic [1:0]  tf_s2;
	logic        keep_s2;
	logic [31:0] ival_s2;
	logic [24:0] sig_s2;
	logic        rb_s2, st_s2, zero_s2;
	logic [4:0]  lz_s2;
	logic signed [9:0] t_s2;
	logic        nan_s2, neg_s2, inf_s2, ez_s2;

	// stage 3 register
	logic [31:0] res_s3;

	// stage 1: decode, widen/narrow, count leading zeros, multiply
	tfc_kind_t   kind_n1;
	logic [31:0] ival_n1;
	logic        wide_n1;
	logic [31:0] lzin_n1;
	logic [15:0] x16e;
	logic [16:0] mult;
	logic [40:0] prod_full;

	always_comb begin
		x16e    = (mode.sf == FMT_UNORM8) ? {raw[7:0], raw[7:0]} : raw[15:0];
		kind_n1 = K_INT;
		ival_n1 = raw;
		wide_n1 = (mode.sf == FMT_UNORM32);
		lzin_n1 = wide_n1 ? raw : {x16e, 16'd0};
		case ({mode.sf, mode.tf})
			{FMT_UNORM8,  FMT_UNORM8}:  ival_n1 = {24'd0, raw[7:0]};
			{FMT_UNORM8,  FMT_UNORM16}: ival_n1 = {16'd0, raw[7:0], raw[7:0]};
			{FMT_UNORM8,  FMT_UNORM32}: ival_n1 = {4{raw[7:0]}};
			{FMT_UNORM16, FMT_UNORM8}:  ival_n1 = {24'd0, div257(raw[15:0])};
			{FMT_UNORM16, FMT_UNORM16}: ival_n1 = {16'd0, raw[15:0]};
			{FMT_UNORM16, FMT_UNORM32}: ival_n1 = {raw[15:0], raw[15:0]};
			{FMT_UNORM32, FMT_UNORM8}: begin
				kind_n1 = K_DIV;
				ival_n1 = {16'd0, div65537(raw)};
			end
			{FMT_UNORM32, FMT_UNORM16}: ival_n1 = {16'd0, div65537(raw)};
			{FMT_UNORM32, FMT_UNORM32}: ival_n1 = raw;
			{FMT_FLOAT32, FMT_FLOAT32}: ival_n1 = raw;
			default: begin
				if (mode.tf == FMT_FLOAT32) begin
					kind_n1 = K_U2F;
					ival_n1 = wide_n1 ? raw : {16'd0, x16e};
				end else begin
					kind_n1 = K_F2U;
				end
			end
		endcase
		case (mode.tf)
			FMT_UNORM8:  mult = 17'd255;
			FMT_UNORM16: mult = 17'd65535;
			default:     mult = 17'd65536;
		endcase
		prod_full = {1'b1, raw[22:0]} * mult;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind_n1;
			tf_s1   <= mode.tf;
			keep_s1 <= keep;
			ival_s1 <= ival_n1;
			wide_s1 <= wide_n1;
			lz_s1   <= lzc32(lzin_n1);
			prod_s1 <= prod_full[39:0];
			e_s1    <= raw[30:23];
			nan_s1  <= (raw[30:23] == 8'hFF) && (raw[22:0] != '0);
			inf_s1  <= (raw[30:23] == 8'hFF) && (raw[22:0] == '0);
			neg_s1  <= raw[31];
			ez_s1   <= (raw[30:23] == 8'h00);
		end
	end

	// stage 2: normalise, round the float product, finish the long narrow
	logic [47:0] stream, shl;
	logic [39:0] p40;
	logic        hi, prb, pst, pup;
	logic [23:0] r24;
	logic signed [9:0] ofs, t_n2;
	logic [24:0] sig_n2;
	logic        rb_n2, st_n2;
	logic [31:0] ival_n2;

	always_comb begin
		stream  = wide_s1 ? {ival_s1, 16'd0} : {3{ival_s1[15:0]}};
		shl     = stream << lz_s1;
		p40     = (tf_s1 == FMT_UNORM8) ? (prod_s1 << 8) : prod_s1;
		hi      = p40[39];
		r24     = hi ? p40[39:16] : p40[38:15];
		prb     = hi ? p40[15] : p40[14];
		pst     = hi ? (|p40[14:0]) : (|p40[13:0]);
		pup     = prb & (pst | r24[0]);
		case (tf_s1)
			FMT_UNORM8:  ofs = -10'sd8;
			FMT_UNORM16: ofs = 10'sd0;
			default:     ofs = 10'sd16;
		endcase
		t_n2    = $signed({2'b00, e_s1}) - 10'sd150 + (hi ? 10'sd16 : 10'sd15) + ofs;
		ival_n2 = (kind_s1 == K_DIV) ? {24'd0, div257(ival_s1[15:0])} : ival_s1;
		if (kind_s1 == K_F2U) begin
			sig_n2 = {1'b0, r24} + {24'd0, pup};
			rb_n2  = 1'b0;
			st_n2  = 1'b0;
		end else begin
			sig_n2 = {1'b0, shl[47:24]};
			rb_n2  = shl[23];
			st_n2  = wide_s1 ? (|shl[22:16]) : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			tf_s2   <= tf_s1;
			keep_s2 <= keep_s1;
			ival_s2 <= ival_n2;
			sig_s2  <= sig_n2;
			rb_s2   <= rb_n2;
			st_s2   <= st_n2;
			zero_s2 <= (ival_s1 == '0);
			lz_s2   <= lz_s1;
			t_s2    <= t_n2;
			nan_s2  <= nan_s1;
			neg_s2  <= neg_s1;
			inf_s2  <= inf_s1;
			ez_s2   <= ez_s1;
		end
	end

	// stage 3: pack the float, shift and saturate the integer
	logic        up3, c3;
	logic [24:0] sum3;
	logic [7:0]  exp3;
	logic [32:0] int33, mx33;
	logic [31:0] smax, res_n3;
	logic [4:0]  rsh;

	always_comb begin
		up3  = rb_s2 & (st_s2 | sig_s2[0]);
		sum3 = sig_s2 + {24'd0, up3};
		c3   = sum3[24];
		exp3 = 8'd126 - {3'd0, lz_s2} + {7'd0, c3};
		rsh  = 5'(-t_s2);
		if (t_s2 >= 10'sd0) begin
			int33 = {8'd0, sig_s2} << t_s2[3:0];
		end else begin
			int33 = {8'd0, sig_s2} >> rsh;
		end
		case (tf_s2)
			FMT_UNORM8:  begin mx33 = 33'd255;   smax = 32'd255; end
			FMT_UNORM16: begin mx33 = 33'd65535; smax = 32'd65535; end
			default:     begin mx33 = 33'h1_0000_0000; smax = 32'hFFFF_FFFF; end
		endcase
		case (kind_s2)
			K_U2F: res_n3 = zero_s2 ? 32'd0 : {1'b0, exp3, (c3 ? 23'd0 : sum3[22:0])};
			K_F2U: begin
				if (nan_s2 || neg_s2 || ez_s2) begin
					res_n3 = 32'd0;
				end else if (inf_s2 || t_s2 >= 10'sd9) begin
					res_n3 = smax;
				end else if (t_s2 <= -10'sd26) begin
					res_n3 = 32'd0;
				end else if (int33 >= mx33) begin
					res_n3 = smax;
				end else begin
					res_n3 = int33[31:0];
				end
			end
			default: res_n3 = ival_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s3 <= keep_s2 ? res_n3 : 32'd0;
		end
	end

	assign res = res_s3;

endmodule

// File: design/texel_format_converter_core.sv
// Top level of the texel format converter: configuration registers, valid
// tracking and four component lanes. Depends on tfc_pkg and tfc_lane.
`timescale 1ns / 1ps
// Usage
//   Input channel in_valid/in_ready/in_data carries one texel request of four
//   32-bit components; output channel out_valid/out_ready/out_data returns the
//   converted texel. Formats and component counts are set through the write
//   port cfg_we/cfg_index/cfg_data while no request is in flight.
//   Pipeline: three lane stages; the accepting edge loads the first, the second
//   follows, and the last is the output register that drives out_data.
//   Throughput: one texel per cycle unless a stall holds the pipeline.
//   Reset: clears all stage valid bits and loads unorm8 to unorm8 with four
//   components each way.
//   Stall: when out_ready is low with a result waiting, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated. A bubble-free
//   stage ahead of an empty output still advances.
module texel_format_converter_core
	import tfc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tfc_in_t          in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output tfc_out_t         out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CNT_W-1:0] cfg_data
);

	logic [1:0]       src_fmt_q, tgt_fmt_q;
	logic [CNT_W-1:0] src_cnt_q, tgt_cnt_q;
	logic             v_s1, v_s2, v_s3;
	logic             adv;
	tfc_mode_t        mode;
	logic [CNT_W-1:0] sc, tc;
	logic [MAX_COMPONENTS-1:0] keep;
	logic [31:0]      raw  [MAX_COMPONENTS];
	logic [31:0]      res  [MAX_COMPONENTS];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= FMT_UNORM8;
			tgt_fmt_q <= FMT_UNORM8;
			src_cnt_q <= CNT_W'(MAX_COMPONENTS);
			tgt_cnt_q <= CNT_W'(MAX_COMPONENTS);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_FORMAT:     src_fmt_q <= cfg_data[1:0];
				REG_TARGET_FORMAT:     tgt_fmt_q <= cfg_data[1:0];
				REG_SOURCE_COMPONENTS: src_cnt_q <= cfg_data;
				REG_TARGET_COMPONENTS: tgt_cnt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance every stage unless a result waits on a stalled receiver
	assign adv      = !v_s3 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// per-component keep: present in the source and written in the target
	always_comb begin
		sc = clamp_count(src_cnt_q);
		tc = clamp_count(tgt_cnt_q);
		for (int k = 0; k < MAX_COMPONENTS; k++) begin
			keep[k] = (CNT_W'(k) < sc) && (CNT_W'(k) < tc);
		end
	end

	assign mode.sf = src_fmt_q;
	assign mode.tf = tgt_fmt_q;

	assign raw[0] = in_data.in_comp0;
	assign raw[1] = in_data.in_comp1;
	assign raw[2] = in_data.in_comp2;
	assign raw[3] = in_data.in_comp3;

	for (genvar g = 0; g < MAX_COMPONENTS; g++) begin : g_lane
		tfc_lane u_lane (
			.clk  (clk),
			.adv  (adv),
			.mode (mode),
			.keep (keep[g]),
			.raw  (raw[g]),
			.res  (res[g])
		);
	end

	assign out_valid          = v_s3;
	assign out_data.out_comp0 = res[0];
	assign out_data.out_comp1 = res[1];
	assign out_data.out_comp2 = res[2];
	assign out_data.out_comp3 = res[3];

endmodule

// File: test/texel_format_converter_core_checker.sv
// Scoreboard for the texel format converter: follows the register writes, predicts
// each converted texel and compares it with the result that the block returns.
// Depends on tfc_pkg.
`timescale 1ns / 1ps
module texel_format_converter_core_checker
	import tfc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  tfc_in_t          in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  tfc_out_t         out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CNT_W-1:0] cfg_data,
	output int               pending,
	output int               errors
);

	logic [1:0]       src_fmt, dst_fmt;
	logic [CNT_W-1:0] src_cnt, dst_cnt;
	tfc_out_t         texel_q[$];

	function automatic logic [31:0] full_scale(input logic [1:0] f);
		case (f)
			FMT_UNORM8:  return 32'hFF;
			FMT_UNORM16: return 32'hFFFF;
			default:     return 32'hFFFF_FFFF;
		endcase
	endfunction

	// x / max, rounded to nearest even in single precision; unorm32 max is 2^32 as a float
	function automatic logic [31:0] unorm_to_float(input logic [31:0] x, input logic [1:0] sf);
		logic [127:0] d, num, q, r;
		int           s;
		logic [8:0]   ex;
		d = (sf == FMT_UNORM32) ? (128'd1 << 32) : 128'(full_scale(sf));
		if (x == 0) begin
			return 32'd0;
		end
		s = 0;
		num = 128'(x);
		q = num / d;
		while (q < (128'd1 << 23)) begin
			s++;
			num = 128'(x) << s;
			q = num / d;
		end
		r = num - q * d;
		if ((2 * r > d) || ((2 * r == d) && q[0])) begin
			q++;
		end
		ex = 9'(150 - s);
		if (q == (128'd1 << 24)) begin
			q = q >> 1;
			ex++;
		end
		return {1'b0, ex[7:0], q[22:0]};
	endfunction

	// single-precision product with the target max, truncated and saturated
	function automatic logic [31:0] float_to_unorm(input logic [31:0] b, input logic [1:0] tf);
		logic [31:0] m;
		logic [63:0] v, keep, rem, half, t;
		int          k, bl, sh;
		m = full_scale(tf);
		if (b[30:23] == 8'hFF) begin
			return (b[22:0] == 0 && !b[31]) ? m : 32'd0;
		end
		if (b[31] || b[30:0] == 0) begin
			return 32'd0;
		end
		v = (b[30:23] == 0) ? 64'(b[22:0]) : 64'({1'b1, b[22:0]});
		k = (b[30:23] == 0) ? -149 : int'(b[30:23]) - 150;
		if (tf == FMT_UNORM32) begin
			k += 32;
		end else begin
			v = v * 64'(m);
		end
		bl = 0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				bl = i + 1;
			end
		end
		if (bl > 24) begin
			sh = bl - 24;
			keep = v >> sh;
			rem = v & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && keep[0])) begin
				keep++;
			end
			if (keep == (64'd1 << 24)) begin
				keep = keep >> 1;
				sh++;
			end
			v = keep;
			k += sh;
		end
		if (k > 32) begin
			return m;
		end
		if (k >= 0) begin
			t = v << k;
		end else if (-k >= 64) begin
			t = 64'd0;
		end else begin
			t = v >> (-k);
		end
		return (t >= 64'(m)) ? m : t[31:0];
	endfunction

	function automatic logic [31:0] convert_comp(input logic [31:0] raw, input logic [1:0] sf,
			input logic [1:0] tf);
		logic [31:0] x, lo, hi;
		if (sf == FMT_FLOAT32) begin
			return (tf == FMT_FLOAT32) ? raw : float_to_unorm(raw, tf);
		end
		x = raw & full_scale(sf);
		if (tf == FMT_FLOAT32) begin
			return unorm_to_float(x, sf);
		end
		lo = full_scale((tf < sf) ? tf : sf);
		hi = full_scale((tf < sf) ? sf : tf);
		if (tf == sf) begin
			return x;
		end
		return (tf > sf) ? x * (hi / lo) : x / (hi / lo);
	endfunction

	function automatic int eff_count(input logic [CNT_W-1:0] c);
		if (c == 0) begin
			return 1;
		end
		return (c > MAX_COMPONENTS) ? MAX_COMPONENTS : int'(c);
	endfunction

	function automatic tfc_out_t convert_texel(input tfc_in_t t);
		logic [31:0] src[4], dst[4];
		src = '{t.in_comp0, t.in_comp1, t.in_comp2, t.in_comp3};
		for (int k = 0; k < 4; k++) begin
			dst[k] = (k < eff_count(src_cnt) && k < eff_count(dst_cnt)) ?
				convert_comp(src[k], src_fmt, dst_fmt) : 32'd0;
		end
		return '{dst[0], dst[1], dst[2], dst[3]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tfc_out_t    exp_t;
		logic [31:0] e[4], a[4];
		if (!arst_n) begin
			src_fmt = FMT_UNORM8;
			dst_fmt = FMT_UNORM8;
			src_cnt = CNT_W'(4);
			dst_cnt = CNT_W'(4);
			texel_q.delete();
			errors  = 0;
		end else begin
			// results first: a request accepted at this edge cannot emerge at it
			if (out_valid && out_ready) begin
				if (texel_q.size() == 0) begin
					$display("%0t: texel returned with none outstanding: %h", $time, out_data);
					errors++;
				end else begin
					exp_t = texel_q.pop_front();
					e = '{exp_t.out_comp0, exp_t.out_comp1, exp_t.out_comp2, exp_t.out_comp3};
					a = '{out_data.out_comp0, out_data.out_comp1, out_data.out_comp2,
						out_data.out_comp3};
					for (int k = 0; k < 4; k++) begin
						if (e[k] !== a[k]) begin
							$display("%0t: out_comp%0d expected %h actual %h", $time, k, e[k],
								a[k]);
							errors++;
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				texel_q.push_back(convert_texel(in_data));
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SOURCE_FORMAT:     src_fmt = cfg_data[1:0];
					REG_TARGET_FORMAT:     dst_fmt = cfg_data[1:0];
					REG_SOURCE_COMPONENTS: src_cnt = cfg_data;
					default:               dst_cnt = cfg_data;
				endcase
			end
		end
		pending = texel_q.size();
	end

endmodule

// File: test/texel_format_converter_core_tb.sv
// Testbench top for texel_format_converter_core: makes the texel and register
// traffic, applies back-pressure and gives the verdict. Depends on tfc_pkg,
// texel_format_converter_core and texel_format_converter_core_checker.
`timescale 1ns / 1ps
module texel_format_converter_core_tb;
	import tfc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASES         = 20;
	localparam int TEXELS_PER_PH  = 62;
	localparam int N_SPECIAL      = 16;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	tfc_in_t          in_data;
	logic             out_valid;
	logic             out_ready;
	tfc_out_t         out_data;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CNT_W-1:0] cfg_data;
	int               pending;
	int               errors;
	int               quiet_cycles;
	logic             in_ready_s;
	logic             calm;

	// boundary patterns: range ends, one, one half, NaN, infinities, values just under one
	logic [31:0] special[N_SPECIAL] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h3F80_0000, 32'h7FC0_0000,
		32'hFF80_0000, 32'h7F80_0000, 32'h3F00_0000, 32'h0000_00FF,
		32'h0000_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h3F7F_FFFF,
		32'hBF80_0000, 32'h0000_0100, 32'h3F80_0001, 32'h0000_0080
	};

	texel_format_converter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	texel_format_converter_core_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.errors    (errors)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// in_ready is settled by the falling edge, so this copy holds its value at the next rise
	always @(negedge clk) begin
		in_ready_s = in_ready;
	end

	// Output side: stall about a third of the time, never during a calm phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 36);
		end
	end

	// Watchdog: abort once nothing has moved on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Pick one component, each kind equally often: fractions near the unit range as
	// floats, boundary patterns, small integers with junk above, or noise.
	function automatic logic [31:0] pick_comp();
		case ($urandom_range(3))
			0: return $urandom;
			1: return special[$urandom_range(N_SPECIAL - 1)];
			2: return {($urandom_range(9) == 0), 8'($urandom_range(127, 100)),
				23'($urandom)};
			default: return ($urandom & 32'hFFFF_0000) | 32'($urandom_range(300));
		endcase
	endfunction

	task automatic send_texel(input tfc_in_t t);
		// idle: drop valid at random before the request, never during a calm phase
		while (!calm && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= t;
		do @(posedge clk); while (!in_ready_s);
	endtask

	task automatic program_regs(input logic [1:0] sf, input logic [1:0] tf,
			input logic [CNT_W-1:0] sc, input logic [CNT_W-1:0] tc);
		logic [CNT_W-1:0] vals[4];
		logic [1:0]       idx[4];
		vals = '{CNT_W'(sf), CNT_W'(tf), sc, tc};
		idx  = '{REG_SOURCE_FORMAT, REG_TARGET_FORMAT, REG_SOURCE_COMPONENTS,
			REG_TARGET_COMPONENTS};
		// hold the write enable across all four writes, drop it afterwards
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		do @(negedge clk); while (pending != 0);
		// the three stages are empty once nothing is pending; idle before reprogramming
		repeat (4) @(posedge clk);
	endtask

	initial begin
		tfc_in_t          t;
		logic [CNT_W-1:0] sc, tc;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_SOURCE_FORMAT;
		cfg_data  = '0;
		calm      = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings first: unorm8 both ways, four components
		for (int i = 0; i < 8; i++) begin
			send_texel('{special[i], special[i + 8], pick_comp(), pick_comp()});
		end
		in_valid <= 1'b0;
		drain();

		// every format pair, then random ones; counts sweep 0..7 including the
		// zero and too-large encodings
		for (int ph = 0; ph < PHASES; ph++) begin
			sc = (ph < 16) ? CNT_W'((ph * 3) % 8) : CNT_W'($urandom_range(7));
			tc = (ph < 16) ? CNT_W'((ph * 5 + 4) % 8) : CNT_W'($urandom_range(7));
			program_regs((ph < 16) ? 2'(ph % 4) : 2'($urandom_range(3)),
				(ph < 16) ? 2'(ph / 4) : 2'($urandom_range(3)), sc, tc);
			calm = (ph == 7);
			for (int i = 0; i < TEXELS_PER_PH; i++) begin
				if (i < 4) begin
					t = '{special[(i * 4) % N_SPECIAL], special[(i * 4 + 1) % N_SPECIAL],
						special[(i * 4 + 2) % N_SPECIAL], special[(i * 4 + 3) % N_SPECIAL]};
				end else begin
					t = '{pick_comp(), pick_comp(), pick_comp(), pick_comp()};
				end
				send_texel(t);
			end
			in_valid <= 1'b0;
			calm = 1'b0;
			drain();
		end

		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
